// ===== rtl/lfcrc_pkg.sv =====
// ----------------------------------------------------------------------------
// lfcrc_pkg
// Shared types and constants for the length-framed CRC-16 check/append core.
// ----------------------------------------------------------------------------
`default_nettype none

package lfcrc_pkg;

   localparam logic [15:0] CRC_POLY  = 16'h8005;
   localparam logic [15:0] LOW_MASK  = 16'h00FF;
   localparam logic [7:0]  MIN_LEN   = 8'd3;
   localparam logic [7:0]  TRAILER   = 8'd2;

   typedef enum logic [2:0] {
      STATUS_BUSY     = 3'd0,
      STATUS_OK       = 3'd1,
      STATUS_MISMATCH = 3'd2,
      STATUS_BADLEN   = 3'd3,
      STATUS_STRAY    = 3'd4
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/length_framed_crc16_check_append_core.sv =====
// ----------------------------------------------------------------------------
// length_framed_crc16_check_append_core
// Length-framed packet checker / CRC-16 appender, one byte per transfer.
// ----------------------------------------------------------------------------
// The block takes one byte per clock while req_stall is low and returns one
// result byte per byte taken. Each byte passes an input register, then the
// framing logic and the unrolled eight-bit CRC update write the result
// register. A new byte can follow every cycle unless a held result stalls.
// The length byte (start_of_packet) opens a packet; the CRC covers the first
// length-2 bytes. Check mode reports ok or mismatch on the last byte; generate
// mode replaces the two trailing bytes with the CRC, low byte first. A length
// below 3 and a byte with no open packet end at once with an error status.
// req_stall rises only while a held result is stalled on the rsp side.
// ----------------------------------------------------------------------------
`default_nettype none

module length_framed_crc16_check_append_core
   import lfcrc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic       req_type,
   input  wire logic       req_start_of_packet,
   input  wire logic [7:0] req_data_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_packet_end,
   output logic [2:0]      rsp_status
);

   // input register
   logic       s1_valid_ff, s1_valid_in;
   logic       s1_mode_ff;
   logic       s1_sop_ff;
   logic [7:0] s1_byte_ff;

   // packet state
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  len_ff, len_in;
   logic [7:0]  pos_ff, pos_in;
   logic        gen_ff, gen_in;
   logic        open_ff, open_in;
   logic        lo_bad_ff, lo_bad_in;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       end_ff, end_in;
   status_type status_ff, status_in;

   logic        adv;
   logic        work;
   logic [15:0] crc_src;
   logic [15:0] crc_fed;
   logic [7:0]  body;
   logic [7:0]  crc_lo;
   logic [7:0]  crc_hi;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;
   assign work      = adv && s1_valid_ff;

   assign crc_src = s1_sop_ff ? 16'h0000 : crc_ff;

   lfcrc_feed u_feed (
      .crc_cur  (crc_src),
      .data     (s1_byte_ff),
      .crc_next (crc_fed)
   );

   assign body   = len_ff - TRAILER;
   assign crc_lo = 8'(crc_ff & LOW_MASK);
   assign crc_hi = 8'((crc_ff >> 8) & LOW_MASK);

   always_comb begin
      s1_valid_in = adv ? req_valid : s1_valid_ff;
      crc_in      = crc_ff;
      len_in      = len_ff;
      pos_in      = pos_ff;
      gen_in      = gen_ff;
      open_in     = open_ff;
      lo_bad_in   = lo_bad_ff;
      out_byte_in = s1_byte_ff;
      end_in      = 1'b0;
      status_in   = STATUS_BUSY;
      if (s1_sop_ff) begin
         if (s1_byte_ff < MIN_LEN) begin
            open_in   = 1'b0;
            end_in    = 1'b1;
            status_in = STATUS_BADLEN;
         end else begin
            crc_in    = crc_fed;
            len_in    = s1_byte_ff;
            pos_in    = 8'd1;
            gen_in    = s1_mode_ff;
            open_in   = 1'b1;
            lo_bad_in = 1'b0;
         end
      end else if (!open_ff) begin
         end_in    = 1'b1;
         status_in = STATUS_STRAY;
      end else if (pos_ff < body) begin
         crc_in = crc_fed;
         pos_in = pos_ff + 8'd1;
      end else if (pos_ff == body) begin
         if (gen_ff) begin
            out_byte_in = crc_lo;
         end else begin
            lo_bad_in = (s1_byte_ff != crc_lo);
         end
         pos_in = pos_ff + 8'd1;
      end else begin
         if (gen_ff) begin
            out_byte_in = crc_hi;
            status_in   = STATUS_OK;
         end else if (lo_bad_ff || (s1_byte_ff != crc_hi)) begin
            status_in = STATUS_MISMATCH;
         end else begin
            status_in = STATUS_OK;
         end
         end_in  = 1'b1;
         open_in = 1'b0;
         pos_in  = 8'd0;
      end
      rsp_valid_in = adv ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         crc_ff       <= 16'h0000;
         len_ff       <= 8'd0;
         pos_ff       <= 8'd0;
         gen_ff       <= 1'b0;
         open_ff      <= 1'b0;
         lo_bad_ff    <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (work) begin
            crc_ff    <= crc_in;
            len_ff    <= len_in;
            pos_ff    <= pos_in;
            gen_ff    <= gen_in;
            open_ff   <= open_in;
            lo_bad_ff <= lo_bad_in;
         end
      end
   end

   // payload registers: the input stage loads whenever it advances, the result stage on a transfer
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_mode_ff <= req_type;
         s1_sop_ff  <= req_start_of_packet;
         s1_byte_ff <= req_data_byte;
      end
      if (work) begin
         out_byte_ff <= out_byte_in;
         end_ff      <= end_in;
         status_ff   <= status_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = out_byte_ff;
   assign rsp_packet_end = end_ff;
   assign rsp_status     = status_ff;

`ifndef SYNTHESIS
   a_end_matches_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (end_ff == (status_ff != STATUS_BUSY)))
      else $error("packet_end disagrees with status");

   a_open_len: assert property (@(posedge clock) disable iff (reset)
      open_ff |-> (len_ff >= MIN_LEN))
      else $error("open packet with short length");

   a_open_pos: assert property (@(posedge clock) disable iff (reset)
      open_ff |-> ((pos_ff != 8'd0) && (pos_ff < len_ff)))
      else $error("byte position out of range");

   a_hold_state: assert property (@(posedge clock) disable iff (reset)
      !work |=> $stable(crc_ff) && $stable(pos_ff) && $stable(open_ff))
      else $error("packet state changed without a transfer");
`endif

endmodule

`default_nettype wire

// ===== rtl/lfcrc_feed.sv =====
// ----------------------------------------------------------------------------
// lfcrc_feed
// One-byte CRC-16 update, polynomial 0x8005, data bits fed LSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module lfcrc_feed
   import lfcrc_pkg::*;
(
   input  wire logic [15:0] crc_cur,
   input  wire logic [7:0]  data,
   output logic      [15:0] crc_next
);

   logic [15:0] acc;

   always_comb begin
      acc = crc_cur;
      for (int i = 0; i < 8; i++) begin
         if (data[i] ^ acc[15]) begin
            acc = {acc[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            acc = {acc[14:0], 1'b0};
         end
      end
      crc_next = acc;
   end

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the length-framed CRC-16 check/append core.
// ----------------------------------------------------------------------------
// Directed bytes cover stray bytes, bad lengths, the shortest packets in both
// modes, damaged trailers and a restart. After that, a random stream follows:
// mostly well-formed packets with random content, mixed with truncated
// packets, stray bytes, bad lengths and noise. A scoreboard predicts every
// result byte and checks the rsp channel in order. Both sides idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
   import lfcrc_pkg::*;

   localparam logic MODE_CHECK    = 1'b0;
   localparam logic MODE_GENERATE = 1'b1;
   localparam int   ITEM_TARGET   = 1450;
   localparam int   DRAIN_CYCLES  = 20;

   typedef struct {
      logic [7:0] data;
      logic       last;
      status_type status;
   } frame_result_type;

   class crc_frame_scoreboard;
      frame_result_type expected_q[$];
      int            errors;
      logic [15:0]   crc_acc;
      logic [7:0]    frame_len;
      logic [7:0]    next_pos;
      logic          gen_mode;
      logic          in_frame;
      logic          low_bad;

      function new();
         errors    = 0;
         crc_acc   = '0;
         frame_len = '0;
         next_pos  = '0;
         gen_mode  = 1'b0;
         in_frame  = 1'b0;
         low_bad   = 1'b0;
      endfunction

      // Poly 0x8005, data bits taken LSB first.
      static function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
         for (int i = 0; i < 8; i++) begin
            if (b[i] ^ c[15])
               c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
               c = {c[14:0], 1'b0};
         end
         return c;
      endfunction

      function void note_byte(logic mode, logic sop, logic [7:0] b);
         frame_result_type r;
         logic [7:0]    body;
         r.data   = b;
         r.last   = 1'b0;
         r.status = STATUS_BUSY;
         if (sop) begin
            if (b < MIN_LEN) begin
               in_frame = 1'b0;
               r.last   = 1'b1;
               r.status = STATUS_BADLEN;
            end else begin
               crc_acc   = crc_step(16'h0000, b);
               frame_len = b;
               next_pos  = 8'd1;
               gen_mode  = mode;
               in_frame  = 1'b1;
               low_bad   = 1'b0;
            end
         end else if (!in_frame) begin
            r.last   = 1'b1;
            r.status = STATUS_STRAY;
         end else begin
            body = frame_len - TRAILER;
            if (next_pos < body) begin
               crc_acc  = crc_step(crc_acc, b);
               next_pos = next_pos + 8'd1;
            end else if (next_pos == body) begin
               if (gen_mode)
                  r.data = 8'(crc_acc & LOW_MASK);
               else
                  low_bad = (b != 8'(crc_acc & LOW_MASK));
               next_pos = next_pos + 8'd1;
            end else begin
               if (gen_mode) begin
                  r.data   = crc_acc[15:8];
                  r.status = STATUS_OK;
               end else begin
                  r.status = (low_bad || b != crc_acc[15:8]) ? STATUS_MISMATCH : STATUS_OK;
               end
               r.last   = 1'b1;
               in_frame = 1'b0;
               next_pos = 8'd0;
            end
         end
         expected_q.push_back(r);
      endfunction

      task report_mismatch(string msg);
         errors++;
         $display("%0t ns: MISMATCH %s", $realtime, msg);
      endtask

      task check_result(logic [7:0] d, logic last, logic [2:0] st);
         frame_result_type e;
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result byte=%02h end=%0b status=%0d",
                                      d, last, st));
         end else begin
            e = expected_q.pop_front();
            if (d !== e.data || last !== e.last || st !== e.status)
               report_mismatch($sformatf(
                  "byte=%02h/%02h end=%0b/%0b status=%0d/%0d (got/exp)",
                  d, e.data, last, e.last, st, e.status));
         end
      endtask
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic       req_type = 1'b0;
   logic       req_start_of_packet = 1'b0;
   logic [7:0] req_data_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_packet_end;
   logic [2:0] rsp_status;

   crc_frame_scoreboard sb;
   int  sent_count = 0;
   bit  quiet = 1'b0;

   length_framed_crc16_check_append_core dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_type            (req_type),
      .req_start_of_packet (req_start_of_packet),
      .req_data_byte       (req_data_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_packet_end      (rsp_packet_end),
      .rsp_status          (rsp_status)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("testbench: done, errors");
      $finish;
   end

   // Mostly short gaps, now and then a long one; none during quiet stretches.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      if (r < 98)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_byte(logic mode, logic sop, logic [7:0] d);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_type            <= mode;
      req_start_of_packet <= sop;
      req_data_byte       <= d;
      do @(posedge clock); while (req_stall);
      sb.note_byte(mode, sop, d);
      sent_count++;
   endtask

   // Send a length-framed packet; corrupt damages one trailer bit, and
   // cut_at stops the transfer early to leave the packet open.
   task automatic send_packet(logic mode, int len, bit corrupt, int cut_at);
      logic [7:0]  frame[$];
      logic [15:0] crc;
      logic [7:0]  b;
      int          fill;
      int          k;
      fill = $urandom_range(0, 9);
      frame.push_back(8'(len));
      crc = crc_frame_scoreboard::crc_step(16'h0000, 8'(len));
      for (k = 1; k < len - 2; k++) begin
         b = (fill == 0) ? 8'h00 : (fill == 1) ? 8'hFF : 8'($urandom);
         frame.push_back(b);
         crc = crc_frame_scoreboard::crc_step(crc, b);
      end
      if (mode == MODE_GENERATE) begin
         frame.push_back(8'($urandom));
         frame.push_back(8'($urandom));
      end else begin
         frame.push_back(crc[7:0]);
         frame.push_back(crc[15:8]);
      end
      if (corrupt)
         frame[len - 2 + $urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
      for (k = 0; k < frame.size() && k < cut_at; k++)
         send_byte(k == 0 ? mode : 1'($urandom), k == 0, frame[k]);
   endtask

   task automatic run_directed();
      send_byte(MODE_CHECK, 1'b0, 8'h00);
      send_byte(MODE_GENERATE, 1'b0, 8'hFF);
      send_byte(MODE_CHECK, 1'b1, 8'd0);
      send_byte(MODE_GENERATE, 1'b1, 8'd1);
      send_byte(MODE_CHECK, 1'b1, 8'd2);
      send_packet(MODE_CHECK, 3, 1'b0, 3);
      send_packet(MODE_GENERATE, 3, 1'b0, 3);
      // damage the low trailer byte, then one of the two
      send_byte(MODE_CHECK, 1'b1, 8'd4);
      send_byte(MODE_CHECK, 1'b0, 8'hA5);
      send_byte(MODE_CHECK, 1'b0,
                8'(~crc_frame_scoreboard::crc_step(
                    crc_frame_scoreboard::crc_step(16'h0, 8'd4), 8'hA5)));
      send_byte(MODE_CHECK, 1'b0,
                8'(crc_frame_scoreboard::crc_step(
                    crc_frame_scoreboard::crc_step(16'h0, 8'd4), 8'hA5) >> 8));
      send_packet(MODE_CHECK, 4, 1'b1, 4);
      // abandon an open packet with a new start
      send_packet(MODE_GENERATE, 8, 1'b0, 3);
      send_packet(MODE_CHECK, 3, 1'b0, 3);
   endtask

   task automatic run_random();
      int r;
      int len;
      int n;
      logic mode;
      send_packet(MODE_CHECK, 255, 1'b0, 255);
      while (sent_count < ITEM_TARGET) begin
         if ($urandom_range(0, 19) == 0)
            quiet = ~quiet;
         r    = $urandom_range(0, 99);
         mode = 1'($urandom);
         if (r < 70) begin
            n   = $urandom_range(0, 99);
            len = (n < 2) ? 255 : (n < 12) ? 3 : $urandom_range(4, 24);
            send_packet(mode, len, mode == MODE_CHECK && $urandom_range(0, 4) == 0, len);
         end else if (r < 78) begin
            len = $urandom_range(5, 30);
            send_packet(mode, len, 1'b0, $urandom_range(1, len - 1));
         end else if (r < 86) begin
            repeat ($urandom_range(1, 3)) send_byte(1'($urandom), 1'b0, 8'($urandom));
         end else if (r < 93) begin
            send_byte(mode, 1'b1, 8'($urandom_range(0, 2)));
         end else begin
            repeat ($urandom_range(1, 5))
               send_byte(1'($urandom), $urandom_range(0, 3) == 0, 8'($urandom));
         end
      end
   endtask

   // Receiver: random stall bursts, none while quiet.
   initial begin
      int hold;
      int run;
      wait (!reset);
      forever begin
         hold = pick_gap();
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         run = $urandom_range(1, 8);
         repeat (run) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_out_byte, rsp_packet_end, rsp_status);
   end

   initial begin
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      run_random();
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule

`default_nettype wire
